/* design/tswc_pkg.sv */
// Shared types and constants for the touch swipe window counter.
package tswc_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_X_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_ROW1    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_ROW2    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_ROW3    = 3'd7;

  // Widths of the fixed fields.
  localparam int STAMP_W     = 32;
  localparam int WINDOW_W    = 16;
  localparam int PERIOD_W    = 8;
  localparam int DIST_W      = 10;
  localparam int COUNT_OUT_W = 8;
  localparam int EVENT_W     = 2;
  localparam int ZONE_W      = 3;

  // Register values after reset.
  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST  = 8'd10;
  localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST = 8'd10;
  localparam logic [WINDOW_W-1:0] WINDOW_RST       = 16'd1000;
  localparam logic [DIST_W-1:0]   MIN_DIST_RST     = 10'd30;
  localparam logic [DIST_W-1:0]   ZONE_X_MIN_RST   = 10'd195;
  localparam logic [DIST_W-1:0]   ZONE_ROW1_RST    = 10'd80;
  localparam logic [DIST_W-1:0]   ZONE_ROW2_RST    = 10'd160;
  localparam logic [DIST_W-1:0]   ZONE_ROW3_RST    = 10'd240;

  // Request kinds.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Swipe event codes.
  localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
  localparam logic [EVENT_W-1:0] EV_FORWARD  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_BACKWARD = 2'd2;

  // Zone codes.
  localparam logic [ZONE_W-1:0] ZONE_NONE  = 3'd0;
  localparam logic [ZONE_W-1:0] ZONE_ONE   = 3'd1;
  localparam logic [ZONE_W-1:0] ZONE_TWO   = 3'd2;
  localparam logic [ZONE_W-1:0] ZONE_THREE = 3'd3;
  localparam logic [ZONE_W-1:0] ZONE_BEYOND = 3'd4;

  // Commands from the sequencer to one stamp queue.
  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
  } q_ctrl_t;

  // Status of one stamp queue; stamp is the entry at the tail.
  typedef struct packed {
    logic                   empty;
    logic                   full;
    logic [COUNT_OUT_W-1:0] count_sat;
    logic [STAMP_W-1:0]     stamp;
  } q_stat_t;

endpackage

/* design/tswc_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
module tswc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/tswc_queue.sv */
// Ring queue of swipe timestamps: pointers, fill count and stamp memory.
module tswc_queue #(
  parameter int DEPTH = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tswc_pkg::q_ctrl_t            ctrl,
  input  logic [tswc_pkg::STAMP_W-1:0] push_stamp,
  output tswc_pkg::q_stat_t            stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + tswc_pkg::COUNT_OUT_W;

  logic [PW-1:0] head_r;
  logic [PW-1:0] tail_r;
  logic [CW-1:0] count_r;
  logic [SW-1:0] count_ext;

  // Pointers and fill count; clear has priority over pop and push.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (ctrl.clear) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (ctrl.pop) begin
      tail_r  <= (tail_r == PW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
      count_r <= count_r - 1'b1;
    end else if (ctrl.push) begin
      head_r  <= (head_r == PW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_r <= count_r + 1'b1;
    end
  end

  // The read port always looks at the oldest entry.
  tswc_ram #(
    .WIDTH(tswc_pkg::STAMP_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctrl.push),
    .waddr(head_r),
    .wdata(push_stamp),
    .raddr(tail_r),
    .rdata(stat.stamp)
  );

  // Status, with the visible count saturated at its output width.
  assign count_ext      = SW'(count_r);
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(DEPTH));
  assign stat.count_sat = (count_ext > SW'(255)) ? '1 : count_ext[tswc_pkg::COUNT_OUT_W-1:0];

endmodule

/* design/tswc_age_cmp.sv */
// Shared age check: a stamp has expired when now minus stamp exceeds the window.
module tswc_age_cmp (
  input  logic [tswc_pkg::STAMP_W-1:0]  now_ms,
  input  logic [tswc_pkg::STAMP_W-1:0]  stamp,
  input  logic [tswc_pkg::WINDOW_W-1:0] window_ms,
  output logic                          expired
);

  logic [tswc_pkg::STAMP_W-1:0] age;

  // Age wraps modulo the stamp width.
  assign age     = now_ms - stamp;
  assign expired = age > tswc_pkg::STAMP_W'(window_ms);

endmodule

/* design/touch_swipe_window_counter_unit.sv */
// Channel   | Direction | Handshake           | Payload
// in_       | in        | in_valid/in_ready   | kind, touch_pressed, touch_x, touch_y
// out_      | out       | out_valid/out_ready | counts, swipe_event, zone_code, pulse, overflow
// cfg_      | in        | cfg_we              | cfg_index, cfg_wdata
//
// A clear request passes from idle through the touch and done states. A tick request
// first walks the queue tails with one age compare unit, one stamp at a time: each
// stamp is read from the registered read port of its stamp memory, then compared.
// Reset is synchronous and active low; both queues come up empty with no sweep.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output register while the next request is taken.
module touch_swipe_window_counter_unit #(
  parameter int HISTORY_DEPTH = 128,
  parameter int COORD_BITS    = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic                                 in_touch_pressed,
  input  logic [COORD_BITS-1:0]                in_touch_x,
  input  logic [COORD_BITS-1:0]                in_touch_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tswc_pkg::COUNT_OUT_W-1:0]     out_forward_count,
  output logic [tswc_pkg::COUNT_OUT_W-1:0]     out_backward_count,
  output logic [tswc_pkg::EVENT_W-1:0]         out_swipe_event,
  output logic [tswc_pkg::ZONE_W-1:0]          out_zone_code,
  output logic                                 out_frame_pulse,
  output logic                                 out_overflow_flag,
  input  logic                                 cfg_we,
  input  logic [tswc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tswc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int CMP_W = (COORD_BITS > tswc_pkg::DIST_W) ? COORD_BITS : tswc_pkg::DIST_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_RD,
    ST_EXP_CMP,
    ST_TOUCH,
    ST_DONE
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [tswc_pkg::PERIOD_W-1:0] tick_period_r;
  logic [tswc_pkg::PERIOD_W-1:0] frame_period_r;
  logic [tswc_pkg::WINDOW_W-1:0] window_r;
  logic [tswc_pkg::DIST_W-1:0]   min_dist_r;
  logic [tswc_pkg::DIST_W-1:0]   zone_x_min_r;
  logic [tswc_pkg::DIST_W-1:0]   zone_row1_r;
  logic [tswc_pkg::DIST_W-1:0]   zone_row2_r;
  logic [tswc_pkg::DIST_W-1:0]   zone_row3_r;

  // Block state and the request being worked on.
  logic [tswc_pkg::STAMP_W-1:0]  time_r;
  logic [tswc_pkg::PERIOD_W-1:0] frame_cnt_r;
  logic                          touching_r;
  logic [COORD_BITS-1:0]         start_x_r;
  logic [COORD_BITS-1:0]         start_y_r;
  logic                          kind_r;
  logic                          pressed_r;
  logic [COORD_BITS-1:0]         x_r;
  logic [COORD_BITS-1:0]         y_r;
  logic                          pulse_r;
  logic [tswc_pkg::EVENT_W-1:0]  event_r;
  logic [tswc_pkg::ZONE_W-1:0]   zone_r;
  logic                          ovf_r;
  logic                          sel_bwd_r;

  // Output register.
  logic                             out_valid_r;
  logic [tswc_pkg::COUNT_OUT_W-1:0] out_fwd_r;
  logic [tswc_pkg::COUNT_OUT_W-1:0] out_bwd_r;
  logic [tswc_pkg::EVENT_W-1:0]     out_event_r;
  logic [tswc_pkg::ZONE_W-1:0]      out_zone_r;
  logic                             out_pulse_r;
  logic                             out_ovf_r;

  logic                          accept;
  logic                          out_load;
  logic [tswc_pkg::PERIOD_W-1:0] frame_inc;
  logic [tswc_pkg::STAMP_W-1:0]  time_nxt;
  tswc_pkg::q_ctrl_t             fwd_ctrl;
  tswc_pkg::q_ctrl_t             bwd_ctrl;
  tswc_pkg::q_stat_t             fwd_stat;
  tswc_pkg::q_stat_t             bwd_stat;
  tswc_pkg::q_stat_t             sel_stat;
  logic                          expired;
  logic [COORD_BITS-1:0]         dx;
  logic [COORD_BITS-1:0]         dy;
  logic                          is_swipe;
  logic                          release_swipe;
  logic                          go_fwd;
  logic                          tgt_full;
  logic [CMP_W-1:0]              y_ext;
  logic [tswc_pkg::ZONE_W-1:0]   zone_nxt;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign frame_inc = frame_cnt_r + 1'b1;
  assign time_nxt  = time_r + tswc_pkg::STAMP_W'(tick_period_r);

  // Queue chosen by the expiry walk, and the shared age check on its tail.
  assign sel_stat = sel_bwd_r ? bwd_stat : fwd_stat;

  tswc_age_cmp u_age (
    .now_ms   (time_r),
    .stamp    (sel_stat.stamp),
    .window_ms(window_r),
    .expired  (expired)
  );

  // Swipe decision on a release after a press.
  assign dx            = (start_x_r > x_r) ? start_x_r - x_r : x_r - start_x_r;
  assign dy            = (start_y_r > y_r) ? start_y_r - y_r : y_r - start_y_r;
  assign is_swipe      = (CMP_W'(dx) > CMP_W'(min_dist_r)) ||
                         (CMP_W'(dy) > CMP_W'(min_dist_r));
  assign release_swipe = (kind_r == tswc_pkg::KIND_TICK) && !pressed_r && touching_r && is_swipe;
  assign go_fwd        = start_y_r > y_r;
  assign tgt_full      = go_fwd ? fwd_stat.full : bwd_stat.full;

  // Zone lookup; row bounds are tested in order and the first match wins.
  assign y_ext = CMP_W'(y_r);
  always_comb begin
    zone_nxt = tswc_pkg::ZONE_NONE;
    if (pressed_r && (CMP_W'(x_r) >= CMP_W'(zone_x_min_r))) begin
      priority if (y_ext <= CMP_W'(zone_row1_r)) zone_nxt = tswc_pkg::ZONE_ONE;
      else if (y_ext <= CMP_W'(zone_row2_r)) zone_nxt = tswc_pkg::ZONE_TWO;
      else if (y_ext <= CMP_W'(zone_row3_r)) zone_nxt = tswc_pkg::ZONE_THREE;
      else zone_nxt = tswc_pkg::ZONE_BEYOND;
    end
  end

  // Queue commands from the sequencer.
  always_comb begin
    fwd_ctrl = '0;
    bwd_ctrl = '0;
    unique case (state_r)
      ST_EXP_CMP: begin
        fwd_ctrl.pop = expired && !sel_bwd_r;
        bwd_ctrl.pop = expired && sel_bwd_r;
      end
      ST_TOUCH: begin
        if (kind_r == tswc_pkg::KIND_CLEAR) begin
          fwd_ctrl.clear = 1'b1;
          bwd_ctrl.clear = 1'b1;
        end else begin
          fwd_ctrl.push = release_swipe && go_fwd && !fwd_stat.full;
          bwd_ctrl.push = release_swipe && !go_fwd && !bwd_stat.full;
        end
      end
      default: begin
      end
    endcase
  end

  tswc_queue #(.DEPTH(HISTORY_DEPTH)) u_fwd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (fwd_ctrl),
    .push_stamp(time_r),
    .stat      (fwd_stat)
  );

  tswc_queue #(.DEPTH(HISTORY_DEPTH)) u_bwd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (bwd_ctrl),
    .push_stamp(time_r),
    .stat      (bwd_stat)
  );

  // Sequencer, configuration registers, block state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      tick_period_r  <= tswc_pkg::TICK_PERIOD_RST;
      frame_period_r <= tswc_pkg::FRAME_PERIOD_RST;
      window_r       <= tswc_pkg::WINDOW_RST;
      min_dist_r     <= tswc_pkg::MIN_DIST_RST;
      zone_x_min_r   <= tswc_pkg::ZONE_X_MIN_RST;
      zone_row1_r    <= tswc_pkg::ZONE_ROW1_RST;
      zone_row2_r    <= tswc_pkg::ZONE_ROW2_RST;
      zone_row3_r    <= tswc_pkg::ZONE_ROW3_RST;
      time_r         <= '0;
      frame_cnt_r    <= '0;
      touching_r     <= 1'b0;
      start_x_r      <= '0;
      start_y_r      <= '0;
      sel_bwd_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        unique case (cfg_index)
          tswc_pkg::CFG_TICK_PERIOD:  tick_period_r  <= cfg_wdata[tswc_pkg::PERIOD_W-1:0];
          tswc_pkg::CFG_FRAME_PERIOD: frame_period_r <= cfg_wdata[tswc_pkg::PERIOD_W-1:0];
          tswc_pkg::CFG_WINDOW:       window_r       <= cfg_wdata[tswc_pkg::WINDOW_W-1:0];
          tswc_pkg::CFG_MIN_DIST:     min_dist_r     <= cfg_wdata[tswc_pkg::DIST_W-1:0];
          tswc_pkg::CFG_ZONE_X_MIN:   zone_x_min_r   <= cfg_wdata[tswc_pkg::DIST_W-1:0];
          tswc_pkg::CFG_ZONE_ROW1:    zone_row1_r    <= cfg_wdata[tswc_pkg::DIST_W-1:0];
          tswc_pkg::CFG_ZONE_ROW2:    zone_row2_r    <= cfg_wdata[tswc_pkg::DIST_W-1:0];
          tswc_pkg::CFG_ZONE_ROW3:    zone_row3_r    <= cfg_wdata[tswc_pkg::DIST_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        // Take a request; a tick advances time and the frame counter at once.
        ST_IDLE: begin
          if (accept) begin
            kind_r    <= in_kind;
            pressed_r <= in_touch_pressed;
            x_r       <= in_touch_x;
            y_r       <= in_touch_y;
            sel_bwd_r <= 1'b0;
            pulse_r   <= (in_kind == tswc_pkg::KIND_TICK) && (frame_inc >= frame_period_r);
            if (in_kind == tswc_pkg::KIND_CLEAR) begin
              state_r <= ST_TOUCH;
            end else begin
              time_r <= time_nxt;
              if (frame_inc >= frame_period_r) begin
                frame_cnt_r <= '0;
              end else begin
                frame_cnt_r <= frame_inc;
              end
              state_r <= ST_EXP_RD;
            end
          end
        end

        // The tail entry is being read; an empty queue ends its walk.
        ST_EXP_RD: begin
          if (sel_stat.empty) begin
            if (sel_bwd_r) begin
              state_r <= ST_TOUCH;
            end else begin
              sel_bwd_r <= 1'b1;
            end
          end else begin
            state_r <= ST_EXP_CMP;
          end
        end

        // Drop the tail if it is too old, otherwise move on.
        ST_EXP_CMP: begin
          if (expired) begin
            state_r <= ST_EXP_RD;
          end else if (!sel_bwd_r) begin
            sel_bwd_r <= 1'b1;
            state_r   <= ST_EXP_RD;
          end else begin
            state_r <= ST_TOUCH;
          end
        end

        // Touch sample handling, or the clear of both queues.
        ST_TOUCH: begin
          zone_r  <= (kind_r == tswc_pkg::KIND_TICK) ? zone_nxt : tswc_pkg::ZONE_NONE;
          ovf_r   <= release_swipe && tgt_full;
          event_r <= (release_swipe && !tgt_full) ?
                     (go_fwd ? tswc_pkg::EV_FORWARD : tswc_pkg::EV_BACKWARD) :
                     tswc_pkg::EV_NONE;
          if (kind_r == tswc_pkg::KIND_TICK) begin
            if (pressed_r) begin
              if (!touching_r) begin
                touching_r <= 1'b1;
                start_x_r  <= x_r;
                start_y_r  <= y_r;
              end
            end else if (touching_r) begin
              touching_r <= 1'b0;
            end
          end
          state_r <= ST_DONE;
        end

        // Hand the result over once the output register is free.
        ST_DONE: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_fwd_r   <= fwd_stat.count_sat;
            out_bwd_r   <= bwd_stat.count_sat;
            out_event_r <= event_r;
            out_zone_r  <= zone_r;
            out_pulse_r <= pulse_r;
            out_ovf_r   <= ovf_r;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_forward_count  = out_fwd_r;
  assign out_backward_count = out_bwd_r;
  assign out_swipe_event    = out_event_r;
  assign out_zone_code      = out_zone_r;
  assign out_frame_pulse    = out_pulse_r;
  assign out_overflow_flag  = out_ovf_r;

endmodule

/* design/tswc_checker.sv */
// Port-level checks on the swipe window counter.
module tswc_port_props (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [tswc_pkg::COUNT_OUT_W-1:0] out_forward_count,
  input logic [tswc_pkg::COUNT_OUT_W-1:0] out_backward_count,
  input logic [tswc_pkg::EVENT_W-1:0]     out_swipe_event,
  input logic [tswc_pkg::ZONE_W-1:0]      out_zone_code,
  input logic                             out_overflow_flag
);

  // One request at a time: the block is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high in the cycle after a request was taken");

  // A stalled result holds its counts.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_forward_count) &&
    $stable(out_backward_count))
    else $error("stalled result changed or dropped");

  // A recorded swipe and a dropped swipe never share one result.
  a_event_excl_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_swipe_event != tswc_pkg::EV_NONE) |-> !out_overflow_flag)
    else $error("swipe recorded and dropped in the same result");

  // A zone is reported only while pressed, a swipe only on release.
  a_zone_excl_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_zone_code != tswc_pkg::ZONE_NONE) |->
    (out_swipe_event == tswc_pkg::EV_NONE) && !out_overflow_flag)
    else $error("zone code reported together with a release");

endmodule

bind touch_swipe_window_counter_unit tswc_port_props u_tswc_port_props (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_forward_count (out_forward_count),
  .out_backward_count(out_backward_count),
  .out_swipe_event   (out_swipe_event),
  .out_zone_code     (out_zone_code),
  .out_overflow_flag (out_overflow_flag)
);
